FILE: hw/rtl/tcw_pkg.sv
// Shared widths, reset constants and the result word type of the text console writer.
package tcw_pkg;

  localparam int ColW  = 7;
  localparam int RowW  = 5;
  localparam int CellW = 16;
  localparam int AttrW = 8;

  localparam logic [AttrW-1:0] AttrReset = 8'h0F;
  localparam logic [7:0]       SpaceCode = 8'h20;

  typedef struct packed {
    logic            scrolled;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [CellW-1:0] cell_value;
  } res_t;

endpackage

FILE: hw/rtl/text_console_writer_top.sv
// Top level of the text console writer: stream ports, attribute register and result register.
// A read or a put without scroll goes through ST_READ or ST_DONE into the result register; the next
// word is taken once the sequencer is back in ST_IDLE and the result register can be emptied, so a
// word is finished before the next one is taken. A put that scrolls clears the new bottom row in the
// cell memory, one cell per cycle. After reset a clearing pass writes every cell to a space with
// attribute 0x0F before any word is taken.
module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25,
  parameter int TAB_STOP       = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_code, read_row, read_col, zero fill
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // cell_value, cursor_col, cursor_row, scrolled, zero fill
);
  import tcw_pkg::*;

  localparam int AddrW = $clog2(SCREEN_ROWS) + ColW;

  logic [AttrW-1:0] attr_q;
  logic             out_valid_q, out_valid_d;
  res_t             out_res_q;
  logic             slot_free;
  logic             res_valid;
  res_t             res;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [AddrW-1:0] mem_raddr;
  logic [CellW-1:0] mem_wdata;
  logic [CellW-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || m_axis_tready;

  tcw_ctrl #(
    .Cols   (SCREEN_COLUMNS),
    .Rows   (SCREEN_ROWS),
    .TabStop(TAB_STOP),
    .AddrW  (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .attr_i     (attr_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .char_code_i(s_axis_tdata[7:0]),
    .read_row_i (s_axis_tdata[12:8]),
    .read_col_i (s_axis_tdata[19:13]),
    .slot_free_i(slot_free),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  tcw_cell_mem #(
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q      <= AttrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q};

`ifndef SYNTHESIS
  a_accept_frees_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result register not empty after an accepted word");

  a_result_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_valid_q || m_axis_tready)
    else $error("result produced while the result register is still occupied");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("word taken while an earlier word is still being processed");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> {1'b0, m_axis_tdata[27:23]} < 6'(SCREEN_ROWS))
    else $error("cursor row beyond the last screen row");
`endif

endmodule

FILE: hw/rtl/tcw_cell_mem.sv
// Screen cell memory with one write port and one registered read port.
module tcw_cell_mem #(
  parameter int AddrW = 12
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [tcw_pkg::CellW-1:0] wdata_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [tcw_pkg::CellW-1:0] rdata_o
);
  import tcw_pkg::*;

  logic [CellW-1:0] mem_q [2**AddrW];
  logic [CellW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/tcw_ctrl.sv
// Sequencer that moves the cursor, writes and reads cells, and clears rows of the screen.
module tcw_ctrl #(
  parameter int Cols    = 80,
  parameter int Rows    = 25,
  parameter int TabStop = 8,
  parameter int AddrW   = $clog2(Rows) + tcw_pkg::ColW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tcw_pkg::AttrW-1:0] attr_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      opcode_i,
  input  logic [7:0]                char_code_i,
  input  logic [tcw_pkg::RowW-1:0]  read_row_i,
  input  logic [tcw_pkg::ColW-1:0]  read_col_i,
  input  logic                      slot_free_i,
  output logic                      mem_we_o,
  output logic [AddrW-1:0]          mem_waddr_o,
  output logic [tcw_pkg::CellW-1:0] mem_wdata_o,
  output logic [AddrW-1:0]          mem_raddr_o,
  input  logic [tcw_pkg::CellW-1:0] mem_rdata_i,
  output logic                      res_valid_o,
  output tcw_pkg::res_t             res_o
);
  import tcw_pkg::*;

  localparam int RW = $clog2(Rows);
  localparam int PW = $clog2(TabStop);

  localparam logic [7:0] ChBackspace = 8'd8;
  localparam logic [7:0] ChTab       = 8'd9;
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChReturn    = 8'd13;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [PW-1:0]   phase_q, phase_d;
  logic [RowW-1:0] top_q, top_d;
  logic [RowW-1:0] clr_row_q, clr_row_d;
  logic [ColW-1:0] clr_col_q, clr_col_d;
  res_t            res_q, res_d;

  logic            accept;
  logic            new_line;
  logic            in_range;
  logic [7:0]      col_inc;
  logic [7:0]      tab_stop;
  logic [RW-1:0]   prow_cur;
  logic [RW-1:0]   prow_rd;

  // Logical rows are stored in a ring; top_q is the physical row shown at the top.
  function automatic logic [RW-1:0] phys_row(input logic [RowW-1:0] lrow,
                                             input logic [RowW-1:0] top);
    logic [RowW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RowW+1)'(Rows)) begin
      sum = sum - (RowW+1)'(Rows);
    end
    return sum[RW-1:0];
  endfunction

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free_i;
  assign prow_cur = phys_row(row_q, top_q);
  assign prow_rd  = phys_row(read_row_i, top_q);
  assign in_range = ({1'b0, read_row_i} < (RowW+1)'(Rows)) &&
                    ({1'b0, read_col_i} < (ColW+1)'(Cols));
  assign col_inc  = {1'b0, col_q} + 8'd1;
  assign tab_stop = {1'b0, col_q} + 8'(TabStop) - 8'(phase_q);
  assign mem_raddr_o = {prow_rd, read_col_i};

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    phase_d     = phase_q;
    top_d       = top_q;
    clr_row_d   = clr_row_q;
    clr_col_d   = clr_col_q;
    res_d       = res_q;
    new_line    = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = {clr_row_q[RW-1:0], clr_col_q};
    mem_wdata_o = {attr_i, SpaceCode};
    res_valid_o = 1'b0;
    res_o       = res_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {AttrReset, SpaceCode};
        if (clr_col_q == ColW'(Cols - 1)) begin
          clr_col_d = '0;
          if (clr_row_q == RowW'(Rows - 1)) begin
            state_d = ST_IDLE;
          end else begin
            clr_row_d = clr_row_q + 1'b1;
          end
        end else begin
          clr_col_d = clr_col_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          res_d.cell_value = '0;
          res_d.scrolled   = 1'b0;
          state_d          = ST_DONE;
          if (opcode_i) begin
            if (in_range) begin
              state_d = ST_READ;
            end
          end else begin
            case (char_code_i)
              ChBackspace: begin
                if (col_q != '0) begin
                  col_d   = col_q - 1'b1;
                  phase_d = (phase_q == '0) ? PW'(TabStop - 1) : phase_q - 1'b1;
                end
              end
              ChTab: begin
                if (tab_stop >= 8'(Cols)) begin
                  new_line = 1'b1;
                end else begin
                  col_d   = tab_stop[ColW-1:0];
                  phase_d = '0;
                end
              end
              ChNewline: begin
                new_line = 1'b1;
              end
              ChReturn: begin
                col_d   = '0;
                phase_d = '0;
              end
              default: begin
                mem_we_o         = 1'b1;
                mem_waddr_o      = {prow_cur, col_q};
                mem_wdata_o      = {attr_i, char_code_i};
                res_d.cell_value = {attr_i, char_code_i};
                if (col_inc >= 8'(Cols)) begin
                  new_line = 1'b1;
                end else begin
                  col_d   = col_inc[ColW-1:0];
                  phase_d = (phase_q == PW'(TabStop - 1)) ? '0 : phase_q + 1'b1;
                end
              end
            endcase
            if (new_line) begin
              col_d   = '0;
              phase_d = '0;
              if ({1'b0, row_q} + 1'b1 < (RowW+1)'(Rows)) begin
                row_d = row_q + 1'b1;
              end else begin
                top_d          = (top_q == RowW'(Rows - 1)) ? '0 : top_q + 1'b1;
                clr_row_d      = top_q;
                clr_col_d      = '0;
                res_d.scrolled = 1'b1;
                state_d        = ST_SCROLL;
              end
            end
          end
          res_d.col = col_d;
          res_d.row = row_d;
        end
      end

      ST_READ: begin
        res_valid_o      = 1'b1;
        res_o.cell_value = mem_rdata_i;
        state_d          = ST_IDLE;
      end

      ST_SCROLL: begin
        mem_we_o = 1'b1;
        if (clr_col_q == ColW'(Cols - 1)) begin
          state_d = ST_DONE;
        end else begin
          clr_col_d = clr_col_q + 1'b1;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      col_q     <= '0;
      row_q     <= '0;
      phase_q   <= '0;
      top_q     <= '0;
      clr_row_q <= '0;
      clr_col_q <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      phase_q   <= phase_d;
      top_q     <= top_d;
      clr_row_q <= clr_row_d;
      clr_col_q <= clr_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule
